// File: rtl/fsrch_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsrch_pkg: shared types and constants
// Beat format between the front end, the queue and the search engine,
// command codes and the engine state encoding.
// ---------------------------------------------------------------------------
package fsrch_pkg;

    localparam int KEY_W  = 32;
    localparam int WIDX_W = 10;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // fifo between front end and engine, power of two
    localparam int QDEPTH = 2;

    localparam logic [CNT_W-1:0] CNT_RESET = 11'd1;

    typedef enum logic
    {
        CMD_WRITE  = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    // word index of the registers, taken from paddr[2]
    typedef enum logic
    {
        REG_ELEMENT_COUNT = 1'b0,
        REG_NONE          = 1'b1
    } reg_idx_t;

    // one classified beat; key holds the write value or the search target
    typedef struct packed
    {
        logic              is_search;
        logic              wr_ok;
        logic [WIDX_W-1:0] widx;
        logic [KEY_W-1:0]  key;
    } beat_t;

    typedef enum logic [2:0]
    {
        S_IDLE,
        S_FIB,
        S_PROBE,
        S_CMP,
        S_FCMP,
        S_EMIT
    } eng_state_t;

endpackage

// File: rtl/fsrch_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsrch_front: input stage
// Registers each input beat, sorts it into write or search and flags
// writes that fall outside the store, then pushes it into the queue.
// ---------------------------------------------------------------------------
module fsrch_front
    import fsrch_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [WIDX_W-1:0] write_index,
    input  logic [KEY_W-1:0]  element_value,
    input  logic [KEY_W-1:0]  target,
    input  logic              q_full,
    output logic              push,
    output beat_t             push_beat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = AW + WIDX_W;

    logic              item_vld_reg;
    logic              item_vld_next;
    beat_t             item_reg;
    beat_t             item_next;
    logic              accept;
    logic [XW-1:0]     widx_ext;

    assign push      = item_vld_reg && !q_full;
    assign in_stall  = item_vld_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push_beat = item_reg;
    assign widx_ext  = XW'(write_index);

    always_comb
    begin
        item_next.is_search = (cmd_t'(command) == CMD_SEARCH);
        item_next.wr_ok     = (widx_ext < XW'(DEPTH));
        item_next.widx      = write_index;
        item_next.key       = (cmd_t'(command) == CMD_SEARCH) ? target : element_value;
        item_vld_next       = accept || (item_vld_reg && !push);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
        end
        else
        begin
            item_vld_reg <= item_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/fsrch_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsrch_queue: beat fifo
// Short fifo that lets the front end keep taking beats while the
// engine works on a search.
// ---------------------------------------------------------------------------
module fsrch_queue
    import fsrch_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  beat_t push_beat,
    output logic  full,
    input  logic  pop,
    output logic  q_valid,
    output beat_t q_beat
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    beat_t         slot_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   cnt_reg;
    logic [PW:0]   cnt_next;
    logic          do_pop;

    assign full    = (cnt_reg == (PW+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_beat  = slot_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = push   ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PW+1)'(push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_beat;
        end
    end

endmodule

// File: rtl/fsrch_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fsrch_back: search engine
// Owns the key store, performs writes and runs the fibonacci search
// one probe at a time, with a result register on the output side.
// ---------------------------------------------------------------------------
module fsrch_back
    import fsrch_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] element_count,
    input  logic             q_valid,
    input  beat_t            q_beat,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             found,
    output logic [POS_W-1:0] position
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW = AW + 2;
    localparam int XW = AW + CNT_W + 1;
    localparam int PX = AW + POS_W;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    eng_state_t       state_reg;
    eng_state_t       state_next;
    logic [FW-1:0]    fm_reg, fm_next;
    logic [FW-1:0]    f1_reg, f1_next;
    logic [FW-1:0]    f2_reg, f2_next;
    logic [FW-1:0]    n_reg, n_next;
    logic [FW-1:0]    ofs1_reg, ofs1_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [KEY_W-1:0] tgt_reg, tgt_next;
    logic             res_found_reg, res_found_next;
    logic [AW-1:0]    res_idx_reg, res_idx_next;
    logic             out_vld_reg, out_vld_next;
    logic             out_found_reg;
    logic [POS_W-1:0] out_pos_reg;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic             load_out;
    logic             out_free;
    logic [XW-1:0]    cnt_ext;
    logic [FW-1:0]    n_clip;
    logic [FW-1:0]    probe_raw;
    logic [FW-1:0]    probe_idx;
    logic             key_lt;
    logic             key_eq;
    logic [PX-1:0]    res_idx_ext;

    assign cnt_ext  = XW'(element_count);
    assign n_clip   = (cnt_ext > XW'(DEPTH)) ? FW'(DEPTH) : FW'(cnt_ext);
    assign wr_addr  = AW'(PX'(q_beat.widx));
    assign key_lt   = $signed(rd_data_reg) < $signed(tgt_reg);
    assign key_eq   = (rd_data_reg == tgt_reg);
    assign out_free = !out_vld_reg || !out_stall;
    // probe at offset + f2, offset held as offset + 1
    assign probe_raw = ofs1_reg + f2_reg - FW'(1);
    assign probe_idx = (probe_raw > n_reg - FW'(1)) ? n_reg - FW'(1) : probe_raw;
    assign res_idx_ext = PX'(res_idx_reg);

    always_comb
    begin
        state_next     = state_reg;
        fm_next        = fm_reg;
        f1_next        = f1_reg;
        f2_next        = f2_reg;
        n_next         = n_reg;
        ofs1_next      = ofs1_reg;
        idx_next       = idx_reg;
        tgt_next       = tgt_reg;
        res_found_next = res_found_reg;
        res_idx_next   = res_idx_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        load_out       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    pop = 1'b1;
                    if (!q_beat.is_search)
                    begin
                        wr_en = q_beat.wr_ok;
                    end
                    else
                    begin
                        tgt_next       = q_beat.key;
                        n_next         = n_clip;
                        fm_next        = FW'(1);
                        f1_next        = FW'(1);
                        f2_next        = '0;
                        ofs1_next      = '0;
                        res_found_next = 1'b0;
                        res_idx_next   = '0;
                        state_next     = (n_clip == '0) ? S_EMIT : S_FIB;
                    end
                end
            end

            S_FIB:
            begin
                // smallest fibonacci number not below the count
                if (fm_reg < n_reg)
                begin
                    f2_next = f1_reg;
                    f1_next = fm_reg;
                    fm_next = f1_reg + fm_reg;
                end
                else
                begin
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (fm_reg > FW'(1))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = AW'(probe_idx);
                    idx_next   = AW'(probe_idx);
                    state_next = S_CMP;
                end
                else if (f1_reg != '0 && ofs1_reg < n_reg)
                begin
                    // closing check of the entry just past the offset
                    rd_en      = 1'b1;
                    rd_addr    = AW'(ofs1_reg);
                    idx_next   = AW'(ofs1_reg);
                    state_next = S_FCMP;
                end
                else
                begin
                    state_next = S_EMIT;
                end
            end

            S_CMP:
            begin
                if (key_eq)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = idx_reg;
                    state_next     = S_EMIT;
                end
                else if (key_lt)
                begin
                    fm_next    = f1_reg;
                    f1_next    = f2_reg;
                    f2_next    = f1_reg - f2_reg;
                    ofs1_next  = FW'(idx_reg) + FW'(1);
                    state_next = S_PROBE;
                end
                else
                begin
                    fm_next    = f2_reg;
                    f1_next    = f1_reg - f2_reg;
                    f2_next    = f2_reg + f2_reg - f1_reg;
                    state_next = S_PROBE;
                end
            end

            S_FCMP:
            begin
                if (key_eq)
                begin
                    res_found_next = 1'b1;
                    res_idx_next   = idx_reg;
                end
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_vld_next = load_out || (out_vld_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fm_reg        <= fm_next;
        f1_reg        <= f1_next;
        f2_reg        <= f2_next;
        n_reg         <= n_next;
        ofs1_reg      <= ofs1_next;
        idx_reg       <= idx_next;
        tgt_reg       <= tgt_next;
        res_found_reg <= res_found_next;
        res_idx_reg   <= res_idx_next;
        if (load_out)
        begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_idx_ext[POS_W-1:0];
        end
    end

    // key store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_beat.key;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_vld_reg;
    assign found     = out_found_reg;
    assign position  = out_pos_reg;

endmodule

// File: rtl/fibonacci_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fibonacci_search_core: fibonacci search over a store of sorted keys
// Top level with the register port, the input stage, the beat fifo
// and the search engine that owns the key store.
// ---------------------------------------------------------------------------
// A write beat (command 0) puts element_value into the store at write_index
// and gives no result; indexes at or beyond DEPTH are dropped. A search beat
// (command 1) gives one result: found, and position of the match (0 on a
// miss). The store must be loaded in ascending signed order, and every entry
// below element_count must be written before a search reads it; the store
// has no reset. element_count is clipped to DEPTH; a count of 0 always
// misses. Beats pass through an input register and a two-beat fifo, so the
// input keeps flowing while the engine searches until the fifo fills. A write
// is done on dispatch and leaves the engine idle. A search steps through
// dispatch, the fibonacci steps until F(m) >= count, then per probe a
// registered store read followed by compare and narrow, the closing check
// and the load of the result register; the engine takes no new beat until
// that load. The single store read port sets the probe rate.
// ---------------------------------------------------------------------------
module fibonacci_search_core
    import fsrch_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    // input beats
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              command,
    input  logic [WIDX_W-1:0] write_index,
    input  logic [KEY_W-1:0]  element_value,
    input  logic [KEY_W-1:0]  target,
    // result beats
    output logic              out_valid,
    input  logic              out_stall,
    output logic              found,
    output logic [POS_W-1:0]  position
);

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             cfg_wr;
    reg_idx_t         reg_sel;

    logic             q_full;
    logic             push;
    beat_t            push_beat;
    logic             pop;
    logic             q_valid;
    beat_t            q_beat;

    // register port: no wait states, word index in paddr[2]
    assign pready  = 1'b1;
    assign reg_sel = reg_idx_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cfg_wr && reg_sel == REG_ELEMENT_COUNT)
        begin
            cnt_next = pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_ELEMENT_COUNT: prdata = APB_DW'(cnt_reg);
            default:           prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CNT_RESET;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // input register and classification
    fsrch_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .write_index   (write_index),
        .element_value (element_value),
        .target        (target),
        .q_full        (q_full),
        .push          (push),
        .push_beat     (push_beat)
    );

    // decouples the input side from the search engine
    fsrch_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_beat (push_beat),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_beat    (q_beat)
    );

    // key store and search sequencer
    fsrch_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .element_count (cnt_reg),
        .q_valid       (q_valid),
        .q_beat        (q_beat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .position      (position)
    );

endmodule

// File: tb/sv/tb_fibonacci_search_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_fibonacci_search_core: self-checking bench for the fibonacci search core
// Loads key sets through the beat port, runs searches against them and
// compares each result beat with a cycle-free model of the probe sequence.
// Covers count extremes and clipping, zero count, unsorted stores and random
// idle phases on the input and stall phases on the output.
// ---------------------------------------------------------------------------
module tb_fibonacci_search_core;
    import fsrch_pkg::*;

    localparam int DEPTH         = 1024;
    // random beats, the full-depth fill included
    localparam int RANDOM_BEATS  = 1400;
    // covers a write still in the input register, fifo and engine
    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 80;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 100;

    localparam logic signed [KEY_W-1:0] KEY_MIN = {1'b1, {(KEY_W-1){1'b0}}};
    localparam logic signed [KEY_W-1:0] KEY_MAX = {1'b0, {(KEY_W-1){1'b1}}};

    typedef struct packed
    {
        logic             found;
        logic [POS_W-1:0] position;
    } search_result_t;

    // dut ports, all inputs known from time zero
    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;
    logic              in_valid      = 1'b0;
    logic              in_stall;
    logic              command       = CMD_WRITE;
    logic [WIDX_W-1:0] write_index   = '0;
    logic [KEY_W-1:0]  element_value = '0;
    logic [KEY_W-1:0]  target        = '0;
    logic              out_valid;
    logic              out_stall     = 1'b0;
    logic              found;
    logic [POS_W-1:0]  position;

    // model state: key store and the count register as the core holds them
    logic signed [KEY_W-1:0] key_store [DEPTH];
    logic [CNT_W-1:0]        elem_count = CNT_RESET;

    // search results still owed by the core, oldest first
    search_result_t pending_results [$];

    // traffic shaping, in percent of cycles
    int sender_idle_pct = 0;
    int stall_pct       = 0;

    int beat_count   = 0;
    int search_count = 0;
    int hit_count    = 0;
    int config_count = 0;
    int error_count  = 0;
    int cycle_count  = 0;

    fibonacci_search_core #(
        .DEPTH (DEPTH)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .write_index   (write_index),
        .element_value (element_value),
        .target        (target),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .position      (position)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // run guard
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver stall, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    function automatic void flag_mismatch(input string field, input longint want,
                                          input longint got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
    endfunction

    // fibonacci search over the model store, same probe order as the core
    function automatic search_result_t predict_search(input logic signed [KEY_W-1:0] key);
        int             n;
        int             fib_lo;
        int             fib_mid;
        int             fib_top;
        int             offset;
        int             hit;
        int             idx;
        search_result_t res;
        n = int'(elem_count);
        if (n > DEPTH)
            n = DEPTH;
        hit = -1;
        if (n > 0)
        begin
            // smallest F(m) at or above the count
            fib_lo  = 0;
            fib_mid = 1;
            fib_top = 1;
            while (fib_top < n)
            begin
                fib_lo  = fib_mid;
                fib_mid = fib_top;
                fib_top = fib_lo + fib_mid;
            end
            offset = -1;
            while (fib_top > 1 && hit < 0)
            begin
                idx = offset + fib_lo;
                if (idx > n - 1)
                    idx = n - 1;
                if (idx < 0)
                    idx = 0;
                if (key_store[idx] < key)
                begin
                    // drop the lower part, one fibonacci step down
                    fib_top = fib_mid;
                    fib_mid = fib_lo;
                    fib_lo  = fib_top - fib_mid;
                    offset  = idx;
                end
                else if (key_store[idx] > key)
                begin
                    // drop the upper part, two steps down
                    fib_top = fib_lo;
                    fib_mid = fib_mid - fib_lo;
                    fib_lo  = fib_top - fib_mid;
                end
                else
                    hit = idx;
            end
            // closing check of the entry just past the offset
            if (hit < 0 && fib_mid != 0 && offset + 1 < n && key_store[offset + 1] == key)
                hit = offset + 1;
        end
        res.found    = (hit >= 0);
        res.position = (hit >= 0) ? POS_W'(hit) : '0;
        return res;
    endfunction

    // result checker: every accepted beat against the oldest prediction
    always @(posedge clk)
    begin
        search_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                flag_mismatch("unexpected result beat, out_valid", 0, 1);
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                    flag_mismatch("found", want.found, found);
                if (position !== want.position)
                    flag_mismatch("position", want.position, position);
            end
        end
    end

    // 0: steady, 1: sender gaps, 2: receiver stalls, 3: both
    task automatic set_traffic(input int mode);
        case (mode)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            1:
            begin
                sender_idle_pct = 54;
                stall_pct       = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct       = 54;
            end
            default:
            begin
                sender_idle_pct = 24;
                stall_pct       = 24;
            end
        endcase
    endtask

    // one input beat; returns at the edge that takes it, model updated there
    task automatic send_beat(input cmd_t cmd, input logic [WIDX_W-1:0] widx,
                             input logic [KEY_W-1:0] value, input logic [KEY_W-1:0] key);
        search_result_t res;
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        command       <= cmd;
        write_index   <= widx;
        element_value <= value;
        target        <= key;
        do
            @(posedge clk);
        while (in_stall);
        if (cmd == CMD_WRITE)
            key_store[widx] = value;
        else
        begin
            res = predict_search(key);
            pending_results.push_back(res);
            search_count++;
            if (res.found)
                hit_count++;
        end
        beat_count++;
    endtask

    // write beat with junk in the unused target field
    task automatic store_key(input int idx, input logic [KEY_W-1:0] value);
        send_beat(CMD_WRITE, WIDX_W'(idx), value, $urandom);
    endtask

    // search beat with junk in the unused write fields
    task automatic search_key(input logic [KEY_W-1:0] key);
        send_beat(CMD_SEARCH, WIDX_W'($urandom), $urandom, key);
    endtask

    // input low, all results in, then time for trailing writes to land
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register read of element_count; psel may still be high from a write
    task automatic check_count_reg(input logic [CNT_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {REG_ELEMENT_COUNT, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== APB_DW'(want))
            flag_mismatch("element_count", want, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // register write of element_count, upper word bits random, then read back
    task automatic write_count(input logic [CNT_W-1:0] count);
        logic [APB_DW-1:0] word;
        word             = $urandom;
        word[CNT_W-1:0]  = count;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ELEMENT_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        elem_count = word[CNT_W-1:0];
        config_count++;
        check_count_reg(count);
    endtask

    // ascending keys into entries 0..n-1, spacing drawn per call
    task automatic load_sorted(input int n, input bit span_extremes);
        longint      key_acc;
        int unsigned step_max;
        case ($urandom_range(2))
            0:       step_max = 3;
            1:       step_max = 1000;
            default: step_max = (n == 1) ? 32'hFFFF_FFFF : int'((64'd1 << 32) / n);
        endcase
        if (span_extremes || step_max > 1000)
            key_acc = longint'(KEY_MIN) + longint'($urandom_range(step_max));
        else
            key_acc = longint'($signed($urandom));
        if (span_extremes)
            key_acc = KEY_MIN;
        for (int i = 0; i < n; i++)
        begin
            if (i > 0)
                key_acc = key_acc + longint'($urandom_range(step_max));
            if (key_acc > longint'(KEY_MAX) || (span_extremes && i == n - 1))
                key_acc = KEY_MAX;
            store_key(i, KEY_W'(key_acc));
        end
    endtask

    // mostly keys held in the store, then neighbors, extremes and noise
    function automatic logic [KEY_W-1:0] pick_target(input int live);
        longint pick;
        int     roll;
        roll = $urandom_range(99);
        if (live == 0 || roll < 12)
            return $urandom;
        if (roll < 20)
            return $urandom_range(1) ? KEY_MIN : KEY_MAX;
        pick = key_store[$urandom_range(live - 1)];
        if (roll >= 72)
            pick = pick + ($urandom_range(1) ? 1 : -1);
        if (pick > longint'(KEY_MAX))
            pick = KEY_MAX;
        if (pick < longint'(KEY_MIN))
            pick = KEY_MIN;
        return KEY_W'(pick);
    endfunction

    // count reset value, then the single-entry store, searched by the closing check alone
    task automatic test_reset_count();
        check_count_reg(CNT_RESET);
        store_key(0, -32'sd7);
        search_key(-32'sd7);
        search_key(-32'sd8);
        search_key(32'sd0);
        wait_idle();
    endtask

    // eight keys from the bottom to the top of the signed range
    task automatic test_small_sorted();
        logic signed [KEY_W-1:0] keys [8];
        keys = '{KEY_MIN, -32'sd100, -32'sd1, 32'sd0, 32'sd1, 32'sd100,
                 KEY_MAX - 1, KEY_MAX};
        write_count(CNT_W'(8));
        for (int i = 0; i < 8; i++)
            store_key(i, keys[i]);
        // every entry once, then gaps between entries
        for (int i = 0; i < 8; i++)
            search_key(keys[i]);
        search_key(-32'sd50);
        search_key(32'sd50);
        search_key(32'sd5);
        wait_idle();
    endtask

    // zero count always misses and reads nothing
    task automatic test_zero_count();
        write_count('0);
        search_key(32'sd0);
        search_key(KEY_MAX);
        wait_idle();
    endtask

    // whole store filled, then full count and counts clipped to depth
    task automatic test_full_depth();
        longint      key_acc;
        int unsigned step_max;
        write_count(CNT_W'(DEPTH));
        step_max = int'((64'd1 << 32) / DEPTH);
        key_acc  = KEY_MIN;
        for (int i = 0; i < DEPTH; i++)
        begin
            // every traffic mode over a quarter of the fill
            set_traffic(i / (DEPTH / 4));
            if (i > 0)
                key_acc = key_acc + longint'($urandom_range(step_max));
            if (key_acc > longint'(KEY_MAX) || i == DEPTH - 1)
                key_acc = KEY_MAX;
            store_key(i, KEY_W'(key_acc));
        end
        set_traffic(3);
        search_key(KEY_MIN);
        search_key(KEY_MAX);
        repeat (18) search_key(pick_target(DEPTH));
        wait_idle();
        // counts above depth search the whole store
        write_count(CNT_W'(DEPTH + 1));
        repeat (8) search_key(pick_target(DEPTH));
        wait_idle();
        write_count({CNT_W{1'b1}});
        repeat (8) search_key(pick_target(DEPTH));
        wait_idle();
    endtask

    // phases of random count, optional fresh prefix, searches and stray writes
    task automatic test_random_phases(input int fill_start);
        int phase;
        int roll;
        int count;
        int live;
        phase = 0;
        while (beat_count - fill_start < RANDOM_BEATS)
        begin
            set_traffic(phase % 4);
            roll = $urandom_range(99);
            if (roll < 8)
                count = 0;
            else if (roll < 70)
                count = $urandom_range(1, 40);
            else if (roll < 90)
                count = $urandom_range(41, DEPTH);
            else
                count = $urandom_range(DEPTH + 1, (1 << CNT_W) - 1);
            write_count(CNT_W'(count));
            live = (count > DEPTH) ? DEPTH : count;
            if (live != 0 && live <= 48 && $urandom_range(3) != 0)
                load_sorted(live, $urandom_range(3) == 0);
            repeat ($urandom_range(8, 20))
            begin
                // stray writes may leave the store unsorted
                if ($urandom_range(99) < 12)
                    store_key($urandom_range(DEPTH - 1), $urandom);
                else
                    search_key(pick_target(live));
            end
            wait_idle();
            phase++;
        end
    endtask

    initial
    begin
        int fill_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_traffic(0);
        test_reset_count();
        test_small_sorted();
        test_zero_count();

        // random part: full fill first, so any count reads written entries only
        fill_start = beat_count;
        test_full_depth();
        test_random_phases(fill_start);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d beats: %0d searches with %0d hits, %0d count writes",
                 beat_count, search_count, hit_count, config_count);
        $display("counts from 0 to 2047 with clipping, unsorted stores, idle and stall phases");
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: filelist.f
rtl/fsrch_pkg.sv
rtl/fsrch_front.sv
rtl/fsrch_queue.sv
rtl/fsrch_back.sv
rtl/fibonacci_search_core.sv
tb/sv/tb_fibonacci_search_core.sv
